[src/igl_pkg.sv]
// Shared constants, codes and controller/datapath interface types for the group lookup unit.
package igl_pkg;

    // Table geometry
    localparam int MAX_GROUPS = 256;
    localparam int SIZE_BITS  = 16;
    localparam int IDX_W      = $clog2(MAX_GROUPS);
    localparam int CNT_W      = $clog2(MAX_GROUPS + 1);

    // Field widths of the input and result words
    localparam int CMD_W  = 2;
    localparam int VAL_W  = 32;
    localparam int STAT_W = 2;
    localparam int GRP_W  = 9;

    // Command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_QUERY  = 2'd2
    } cmd_t;

    // Result status codes
    typedef enum logic [STAT_W-1:0] {
        STAT_DONE  = 2'd0,
        STAT_FOUND = 2'd1,
        STAT_MISS  = 2'd2,
        STAT_FULL  = 2'd3
    } status_t;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_PROBE,
        S_CHECK,
        S_FINISH
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;        // take the input word and act on clear/append/query start
        logic issue_read;  // read the bounds at the middle of the open range
        logic narrow;      // shrink the range after a failed probe
        logic set_miss;    // result: not in any group
        logic set_found;   // result: group of the last probe
        logic publish;     // move the pending result to the output register
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic item_query;  // the offered word is a query
        logic range_open;  // search range still holds entries
        logic hit;         // probed interval holds the value
        logic out_free;    // output register can take a result this cycle
    } dp_stat_t;

endpackage

[src/igl_datapath.sv]
// Datapath: bounds memory, group count, running start, search range and output register.
module igl_datapath
    import igl_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  ctrl_cmd_t           cmd,
    output dp_stat_t            stat,
    input  logic [CMD_W-1:0]    s_command,
    input  logic [VAL_W-1:0]    s_value,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [STAT_W-1:0]   m_status,
    output logic [GRP_W-1:0]    m_group_number
);

    // Interval bounds, {first, last} per group
    logic [2*VAL_W-1:0] bounds_mem [MAX_GROUPS];
    logic [2*VAL_W-1:0] rd_reg;

    logic [CNT_W-1:0]   count_reg, count_next;
    logic [VAL_W-1:0]   start_reg, start_next;
    logic [VAL_W-1:0]   val_reg;
    logic [CNT_W-1:0]   left_reg, left_next;
    logic [CNT_W-1:0]   rexcl_reg, rexcl_next;
    logic [IDX_W-1:0]   pos_reg;
    logic [STAT_W-1:0]  res_status_reg, res_status_next;
    logic [GRP_W-1:0]   res_group_reg, res_group_next;
    logic               m_valid_reg;
    logic [STAT_W-1:0]  m_status_reg;
    logic [GRP_W-1:0]   m_group_reg;

    logic               full;
    logic               append_we;
    logic [VAL_W-1:0]   size;
    logic [VAL_W-1:0]   last_bound;
    logic [CNT_W:0]     mid_sum;
    logic [IDX_W-1:0]   mid_idx;
    logic [CNT_W-1:0]   pos_plus1;
    logic [VAL_W-1:0]   lo, hi;

    // Append arithmetic
    assign full       = (count_reg >= CNT_W'(MAX_GROUPS));
    assign size       = VAL_W'(s_value[SIZE_BITS-1:0]);
    assign last_bound = start_reg + size - VAL_W'(1);
    assign append_we  = cmd.load && (s_command == CMD_APPEND) && !full;

    // Middle of the open range [left, rexcl)
    assign mid_sum   = {1'b0, left_reg} + {1'b0, rexcl_reg} - (CNT_W+1)'(1);
    assign mid_idx   = mid_sum[IDX_W:1];
    assign pos_plus1 = CNT_W'(pos_reg) + CNT_W'(1);

    // Probe compare on the registered read
    assign lo = rd_reg[2*VAL_W-1:VAL_W];
    assign hi = rd_reg[VAL_W-1:0];

    assign stat.item_query = (s_command == CMD_QUERY);
    assign stat.range_open = (left_reg < rexcl_reg);
    assign stat.hit        = (val_reg >= lo) && (val_reg <= hi);
    assign stat.out_free   = !m_valid_reg || m_ready;

    // Bounds memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (append_we) begin
            bounds_mem[count_reg[IDX_W-1:0]] <= {start_reg, last_bound};
        end
        if (cmd.issue_read) begin
            rd_reg <= bounds_mem[mid_idx];
        end
    end

    // Next-value logic for table state, range and pending result
    always_comb begin
        count_next      = count_reg;
        start_next      = start_reg;
        left_next       = left_reg;
        rexcl_next      = rexcl_reg;
        res_status_next = res_status_reg;
        res_group_next  = res_group_reg;

        if (cmd.load) begin
            unique case (s_command)
                CMD_CLEAR: begin
                    count_next      = '0;
                    start_next      = VAL_W'(1);
                    res_status_next = STAT_DONE;
                    res_group_next  = '0;
                end
                CMD_APPEND: begin
                    if (full) begin
                        res_status_next = STAT_FULL;
                        res_group_next  = '0;
                    end else begin
                        count_next      = count_reg + CNT_W'(1);
                        start_next      = start_reg + size;
                        res_status_next = STAT_DONE;
                        res_group_next  = GRP_W'(count_reg + CNT_W'(1));
                    end
                end
                CMD_QUERY: begin
                    left_next  = '0;
                    rexcl_next = count_reg;
                end
                default: begin
                    res_status_next = STAT_DONE;
                    res_group_next  = '0;
                end
            endcase
        end

        // Both bounds may move when the stored interval is empty (last below first)
        if (cmd.narrow) begin
            if (val_reg > hi) begin
                left_next = pos_plus1;
            end
            if (val_reg < lo) begin
                rexcl_next = CNT_W'(pos_reg);
            end
        end

        if (cmd.set_miss) begin
            res_status_next = STAT_MISS;
            res_group_next  = '0;
        end
        if (cmd.set_found) begin
            res_status_next = STAT_FOUND;
            res_group_next  = GRP_W'(pos_plus1);
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            start_reg   <= VAL_W'(1);
            m_valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            start_reg <= start_next;
            if (cmd.publish) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        left_reg       <= left_next;
        rexcl_reg      <= rexcl_next;
        res_status_reg <= res_status_next;
        res_group_reg  <= res_group_next;
        if (cmd.load) begin
            val_reg <= s_value;
        end
        if (cmd.issue_read) begin
            pos_reg <= mid_idx;
        end
        if (cmd.publish) begin
            m_status_reg <= res_status_reg;
            m_group_reg  <= res_group_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_group_number = m_group_reg;

endmodule

[src/igl_ctrl.sv]
// Controller: sequences accept, search probes and result hand-off.
module igl_ctrl
    import igl_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  dp_stat_t   stat,
    output ctrl_cmd_t  cmd
);

    state_t state_reg, state_next;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = stat.item_query ? S_PROBE : S_FINISH;
                end
            end
            S_PROBE: begin
                state_next = stat.range_open ? S_CHECK : S_FINISH;
            end
            S_CHECK: begin
                state_next = stat.hit ? S_FINISH : S_PROBE;
            end
            S_FINISH: begin
                if (stat.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            S_PROBE: begin
                cmd.issue_read = stat.range_open;
                cmd.set_miss   = !stat.range_open;
            end
            S_CHECK: begin
                cmd.set_found = stat.hit;
                cmd.narrow    = !stat.hit;
            end
            S_FINISH: begin
                cmd.publish = stat.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

[src/interval_group_lookup_unit.sv]
// Top level of the interval group lookup unit: controller, datapath and checks.
// Keeps a table of up to MAX_GROUPS groups of consecutive numbers starting at 1.
// Each input word is a clear, an append of a group size or a query, and gives
// exactly one result word. Words are taken one at a time. Clear, append and
// unused codes go from accept straight to the finish step, where the result is
// registered into the output register. A query runs a probe step and a check
// step per binary-search probe, and one more probe step when it ends in a miss.
// There are at most 9 probes with 256 groups. Each probe is a registered read of
// the bounds memory followed by a compare of the registered bounds. A finished
// result sits in an output register; while it waits, the next word is accepted
// and worked on, but that word's result is held back until the output register
// frees up.
module interval_group_lookup_unit
    import igl_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [CMD_W-1:0]   s_command,
    input  logic [VAL_W-1:0]   s_value,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [STAT_W-1:0]  m_status,
    output logic [GRP_W-1:0]   m_group_number
);

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    igl_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    igl_datapath u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .stat           (stat),
        .s_command      (s_command),
        .s_value        (s_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_group_number (m_group_number)
    );

    // One word at a time: an accepted word closes the input side
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while a word is in progress");

    // A found result always names a group
    a_found_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status == STAT_FOUND)) |-> (m_group_number != '0))
        else $error("found result with group number zero");

    // Miss and full results carry no group
    a_miss_full_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && ((m_status == STAT_MISS) || (m_status == STAT_FULL)))
            |-> (m_group_number == '0))
        else $error("miss or full result with a group number");

    // A result is published only from the finish step, never straight from accept
    a_no_early_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !(m_valid && !m_ready)) |=> !$rose(m_valid))
        else $error("result appeared in the cycle after accept");

endmodule

[bench/tb_interval_group_lookup_unit.sv]
// Self-checking testbench for the interval group lookup unit: random appends, queries and clears.
`timescale 1ns / 100ps

module tb_interval_group_lookup_unit
    import igl_pkg::*;
();

    localparam int RANDOM_WORDS = 1300;
    localparam int TAIL_CYCLES  = 40;

    // Command code with no meaning to the unit
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    // Expected result word, as the unit should return it
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [GRP_W-1:0]  group_no;
    } result_word_t;

    // Scoreboard: private copy of the group table and the queue of pending results
    class lookup_scoreboard;
        bit [VAL_W-1:0] lo_bound [MAX_GROUPS];
        bit [VAL_W-1:0] hi_bound [MAX_GROUPS];
        int unsigned    group_total;
        bit [VAL_W-1:0] start_next;
        result_word_t   pending_results [$];
        int             errors;

        function new();
            group_total = 0;
            start_next  = 1;
            errors      = 0;
        endfunction

        // Work out the result of one word and move the table on
        function result_word_t predict_lookup(logic [CMD_W-1:0] cmd, logic [VAL_W-1:0] val);
            result_word_t   res;
            bit [VAL_W-1:0] size;
            int             lft;
            int             rgt;
            int             pos;
            int unsigned    hit_no;
            res.status   = STAT_DONE;
            res.group_no = '0;
            case (cmd)
                CMD_CLEAR: begin
                    group_total = 0;
                    start_next  = 1;
                end
                CMD_APPEND: begin
                    size = {{(VAL_W-SIZE_BITS){1'b0}}, val[SIZE_BITS-1:0]};
                    if (group_total >= MAX_GROUPS) begin
                        res.status = STAT_FULL;
                    end else begin
                        lo_bound[group_total] = start_next;
                        hi_bound[group_total] = start_next + size - 1;
                        start_next  = start_next + size;
                        group_total = group_total + 1;
                        res.group_no = group_total[GRP_W-1:0];
                    end
                end
                CMD_QUERY: begin
                    lft    = 0;
                    rgt    = int'(group_total) - 1;
                    hit_no = 0;
                    while (lft <= rgt && hit_no == 0) begin
                        pos = (lft + rgt) / 2;
                        if (val >= lo_bound[pos] && val <= hi_bound[pos]) begin
                            hit_no = pos + 1;
                        end else begin
                            if (val > hi_bound[pos]) lft = pos + 1;
                            if (val < lo_bound[pos]) rgt = pos - 1;
                        end
                    end
                    if (hit_no != 0) begin
                        res.status   = STAT_FOUND;
                        res.group_no = hit_no[GRP_W-1:0];
                    end else begin
                        res.status = STAT_MISS;
                    end
                end
                default: ;  // unused code: table untouched
            endcase
            return res;
        endfunction

        function void note_word(logic [CMD_W-1:0] cmd, logic [VAL_W-1:0] val);
            pending_results.push_back(predict_lookup(cmd, val));
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_word(logic [STAT_W-1:0] st, logic [GRP_W-1:0] grp);
            result_word_t want;
            if (pending_results.size() == 0) begin
                report($sformatf("result word (status %0d, group %0d) with none expected",
                                 st, grp));
            end else begin
                want = pending_results.pop_front();
                if (st !== want.status)
                    report($sformatf("status %0d, expected %0d", st, want.status));
                if (grp !== want.group_no)
                    report($sformatf("group %0d, expected %0d", grp, want.group_no));
            end
        endtask
    endclass

    logic               aclk;
    logic               aresetn        = 1'b0;
    logic               s_valid        = 1'b0;
    logic               s_ready;
    logic [CMD_W-1:0]   s_command      = '0;
    logic [VAL_W-1:0]   s_value        = '0;
    logic               m_valid;
    logic               m_ready        = 1'b0;
    logic [STAT_W-1:0]  m_status;
    logic [GRP_W-1:0]   m_group_number;

    lookup_scoreboard sb;
    int sender_idle = 0;   // percent of cycles the sender holds off
    int recv_stall  = 0;   // percent of cycles the receiver stalls
    int words_sent  = 0;

    interval_group_lookup_unit dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_value        (s_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_group_number (m_group_number)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Offer one word, with a random hold-off first; note it once taken
    task send_word(logic [CMD_W-1:0] cmd, logic [VAL_W-1:0] val);
        while ($urandom_range(0, 99) < sender_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_command <= cmd;
        s_value   <= val;
        do @(posedge aclk); while (!s_ready);
        sb.note_word(cmd, val);
        words_sent++;
    endtask

    // Query value: mostly on or next to a stored boundary
    function automatic logic [VAL_W-1:0] pick_query();
        int unsigned    g;
        bit [VAL_W-1:0] lo;
        bit [VAL_W-1:0] hi;
        if (sb.group_total == 0 || $urandom_range(0, 7) == 0) return $urandom();
        g  = $urandom_range(0, sb.group_total - 1);
        lo = sb.lo_bound[g];
        hi = sb.hi_bound[g];
        case ($urandom_range(0, 6))
            0: return lo - 1;
            1: return lo;
            2: return hi;
            3: return hi + 1;
            4: return sb.start_next;
            default: return (hi >= lo) ? lo + $urandom_range(0, hi - lo) : lo;
        endcase
    endfunction

    // Receiver stalls
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_stall);
    end

    // Result checking
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_word(m_status, m_group_number);
    end

    // Stimulus
    initial begin
        int          n_app;
        int          n_qry;
        int          sel;
        int          phase;
        logic [31:0] v;
        sb = new();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty table, edge sizes, boundaries, unused code, clear
        send_word(CMD_QUERY,  32'h0000_0000);
        send_word(CMD_QUERY,  32'h0000_0001);
        send_word(CMD_QUERY,  32'hFFFF_FFFF);
        send_word(CMD_APPEND, 32'h0000_0001);          // group 1 = {1}
        send_word(CMD_APPEND, 32'hFFFF_0000);          // empty group, high bits ignored
        send_word(CMD_APPEND, 32'h0000_FFFF);          // widest size
        send_word(CMD_APPEND, 32'hABCD_0003);          // size 3
        send_word(CMD_QUERY,  32'h0000_0000);
        send_word(CMD_QUERY,  32'h0000_0001);
        send_word(CMD_QUERY,  32'h0000_0002);
        send_word(CMD_QUERY,  32'h0001_0000);
        send_word(CMD_QUERY,  32'h0001_0001);
        send_word(CMD_QUERY,  32'h0001_0003);
        send_word(CMD_QUERY,  32'h0001_0004);
        send_word(CMD_QUERY,  32'hFFFF_FFFF);
        send_word(CMD_UNUSED, 32'h5A5A_A5A5);          // unused code
        send_word(CMD_QUERY,  32'h0001_0002);
        send_word(CMD_CLEAR,  32'hFFFF_FFFF);
        send_word(CMD_QUERY,  32'h0000_0001);
        send_word(CMD_APPEND, 32'h0000_0000);          // only group is empty
        send_word(CMD_QUERY,  32'h0000_0001);
        send_word(CMD_QUERY,  32'h0000_0000);

        // Random episodes: build a table, then probe it
        while (words_sent < 22 + RANDOM_WORDS) begin
            phase = (words_sent - 22) * 4 / RANDOM_WORDS;
            case (phase)
                0:       begin sender_idle = 0;  recv_stall = 0;  end
                1:       begin sender_idle = 52; recv_stall = 0;  end
                2:       begin sender_idle = 0;  recv_stall = 52; end
                default: begin sender_idle = 28; recv_stall = 28; end
            endcase
            if ($urandom_range(0, 5) != 0) send_word(CMD_CLEAR, $urandom());
            n_app = ($urandom_range(0, 4) == 0) ? $urandom_range(250, 262)
                                                : $urandom_range(0, 24);
            for (int i = 0; i < n_app; i++) begin
                v   = $urandom();
                sel = $urandom_range(0, 9);
                case (sel)
                    0:       v[15:0] = 16'h0000;
                    1:       v[15:0] = 16'hFFFF;
                    2:       ;
                    default: v[15:0] = 16'($urandom_range(1, 12));
                endcase
                if (sel > 4) v[31:16] = 16'h0000;
                send_word(CMD_APPEND, v);
                if ($urandom_range(0, 7) == 0) send_word(CMD_QUERY, pick_query());
            end
            n_qry = $urandom_range(8, 40);
            for (int i = 0; i < n_qry; i++) begin
                sel = $urandom_range(0, 15);
                if (sel == 0)
                    send_word(CMD_UNUSED, $urandom());
                else if (sel == 1)
                    send_word(CMD_APPEND, $urandom_range(0, 8));
                else
                    send_word(CMD_QUERY, pick_query());
            end
        end

        // Drain
        s_valid    <= 1'b0;
        recv_stall = 0;
        while (sb.pending_results.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Watchdog
    initial begin
        #10_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

[filelist.f]
src/igl_pkg.sv
src/igl_datapath.sv
src/igl_ctrl.sv
src/interval_group_lookup_unit.sv
bench/tb_interval_group_lookup_unit.sv
